/* hdl/hsv_pkg.sv */
`timescale 1ns / 1ps

package hsv_pkg;

    localparam int HUE_W  = 9;
    localparam int CH_W   = 8;
    localparam int REM_W  = 6;
    localparam int PROD_W = 14;
    localparam int PNUM_W = 16;
    localparam int QNUM_W = 22;

    localparam logic [HUE_W-1:0] FULL_CIRCLE = 9'd360;
    localparam logic [HUE_W-1:0] SEC1_START  = 9'd60;
    localparam logic [HUE_W-1:0] SEC2_START  = 9'd120;
    localparam logic [HUE_W-1:0] SEC3_START  = 9'd180;
    localparam logic [HUE_W-1:0] SEC4_START  = 9'd240;
    localparam logic [HUE_W-1:0] SEC5_START  = 9'd300;

    localparam logic [REM_W-1:0]  SECTOR_SPAN = 6'd60;
    localparam logic [CH_W-1:0]   LEVEL_MAX   = 8'd255;
    localparam logic [PROD_W-1:0] QT_DEN      = 14'd15300;
    localparam logic [PNUM_W-1:0] P_HALF      = 16'd127;
    localparam logic [QNUM_W-1:0] QT_HALF     = 22'd7650;

    localparam int P_RECIP_W  = 17;
    localparam int QT_RECIP_W = 23;
    localparam logic [P_RECIP_W-1:0]  P_RECIP  = 17'd65794;
    localparam logic [QT_RECIP_W-1:0] QT_RECIP = 23'd4491470;
    localparam int P_SHIFT  = 24;
    localparam int QT_SHIFT = 36;

    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } t_sector;

    typedef struct packed {
        logic [PNUM_W-1:0] pnum;
        logic [QNUM_W-1:0] qnum;
        logic [QNUM_W-1:0] tnum;
    } t_num;

    typedef struct packed {
        logic [CH_W-1:0] p;
        logic [CH_W-1:0] q;
        logic [CH_W-1:0] t;
    } t_lvl;

endpackage

/* hdl/hsv_lvl_div.sv */
`timescale 1ns / 1ps

module hsv_lvl_div
    import hsv_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_num i_num,
    output logic o_valid,
    output t_lvl o_lvl
);

    localparam int PPROD_W = PNUM_W + P_RECIP_W;
    localparam int QPROD_W = QNUM_W + QT_RECIP_W;

    logic [PPROD_W-1:0] w_pprod;
    logic [QPROD_W-1:0] w_qprod;
    logic [QPROD_W-1:0] w_tprod;
    logic               r_valid;
    t_lvl               r_lvl;

    assign w_pprod = {{P_RECIP_W{1'b0}}, i_num.pnum} * {{PNUM_W{1'b0}}, P_RECIP};
    assign w_qprod = {{QT_RECIP_W{1'b0}}, i_num.qnum} * {{QNUM_W{1'b0}}, QT_RECIP};
    assign w_tprod = {{QT_RECIP_W{1'b0}}, i_num.tnum} * {{QNUM_W{1'b0}}, QT_RECIP};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lvl.p <= w_pprod[P_SHIFT+CH_W-1:P_SHIFT];
        r_lvl.q <= w_qprod[QT_SHIFT+CH_W-1:QT_SHIFT];
        r_lvl.t <= w_tprod[QT_SHIFT+CH_W-1:QT_SHIFT];
    end

    assign o_valid = r_valid;
    assign o_lvl   = r_lvl;

endmodule

/* hdl/hsv_to_rgb_converter.sv */
`timescale 1ns / 1ps
// A transaction accepted at a clock edge passes the registers r1, r2, r3, the divider
// output and r5, and then shows on the result ports for one cycle, with o_valid high.
// Throughput: one transaction per clock cycle; o_busy is always low.
// Reset: synchronous and active low; it clears every pipeline valid bit.
// The receiver cannot stall the pipeline.

module hsv_to_rgb_converter
    import hsv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [HUE_W-1:0]  i_hue,
    input  logic [CH_W-1:0]   i_saturation,
    input  logic [CH_W-1:0]   i_brightness,
    output logic              o_busy,
    output logic              o_valid,
    output logic [CH_W-1:0]   o_red,
    output logic [CH_W-1:0]   o_green,
    output logic [CH_W-1:0]   o_blue
);

    logic [HUE_W-1:0]  w_hue;
    logic [HUE_W-1:0]  w_base;
    logic [HUE_W-1:0]  w_diff;
    t_sector           n_sec;

    logic              r1_vld;
    t_sector           r1_sec;
    logic [REM_W-1:0]  r1_rem;
    logic [CH_W-1:0]   r1_sat;
    logic [CH_W-1:0]   r1_val;

    logic              r2_vld;
    t_sector           r2_sec;
    logic [CH_W-1:0]   r2_val;
    logic [PROD_W-1:0] r2_sq;
    logic [PROD_W-1:0] r2_st;
    logic [PNUM_W-1:0] r2_pnum;

    logic              r3_vld;
    t_sector           r3_sec;
    logic [CH_W-1:0]   r3_val;
    t_num              r3_num;

    t_sector           r4_sec;
    logic [CH_W-1:0]   r4_val;
    logic              w4_vld;
    t_lvl              w4_lvl;

    logic              r5_vld;
    logic [CH_W-1:0]   r5_red;
    logic [CH_W-1:0]   r5_green;
    logic [CH_W-1:0]   r5_blue;

    logic [CH_W-1:0]   n_red;
    logic [CH_W-1:0]   n_green;
    logic [CH_W-1:0]   n_blue;

    assign o_busy = 1'b0;

    assign w_hue = (i_hue >= FULL_CIRCLE) ? (i_hue - FULL_CIRCLE) : i_hue;

    always_comb begin
        if (w_hue >= SEC5_START) begin
            n_sec  = SEC_MR;
            w_base = SEC5_START;
        end else if (w_hue >= SEC4_START) begin
            n_sec  = SEC_BM;
            w_base = SEC4_START;
        end else if (w_hue >= SEC3_START) begin
            n_sec  = SEC_CB;
            w_base = SEC3_START;
        end else if (w_hue >= SEC2_START) begin
            n_sec  = SEC_GC;
            w_base = SEC2_START;
        end else if (w_hue >= SEC1_START) begin
            n_sec  = SEC_YG;
            w_base = SEC1_START;
        end else begin
            n_sec  = SEC_RY;
            w_base = '0;
        end
    end

    assign w_diff = w_hue - w_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else begin
            r1_vld <= i_start && !o_busy;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r5_vld <= w4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_sec <= n_sec;
        r1_rem <= w_diff[REM_W-1:0];
        r1_sat <= i_saturation;
        r1_val <= i_brightness;

        r2_sec  <= r1_sec;
        r2_val  <= r1_val;
        r2_sq   <= {{REM_W{1'b0}}, r1_sat} * {{CH_W{1'b0}}, r1_rem};
        r2_st   <= {{REM_W{1'b0}}, r1_sat} * {{CH_W{1'b0}}, SECTOR_SPAN - r1_rem};
        r2_pnum <= ({{CH_W{1'b0}}, r1_val} * {{CH_W{1'b0}}, LEVEL_MAX - r1_sat}) + P_HALF;

        r3_sec      <= r2_sec;
        r3_val      <= r2_val;
        r3_num.pnum <= r2_pnum;
        r3_num.qnum <= ({{PROD_W{1'b0}}, r2_val} * {{CH_W{1'b0}}, QT_DEN - r2_sq})
                       + QT_HALF;
        r3_num.tnum <= ({{PROD_W{1'b0}}, r2_val} * {{CH_W{1'b0}}, QT_DEN - r2_st})
                       + QT_HALF;

        r4_sec <= r3_sec;
        r4_val <= r3_val;

        r5_red   <= n_red;
        r5_green <= n_green;
        r5_blue  <= n_blue;
    end

    hsv_lvl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r3_vld),
        .i_num   (r3_num),
        .o_valid (w4_vld),
        .o_lvl   (w4_lvl)
    );

    always_comb begin
        case (r4_sec)
            SEC_RY: begin
                n_red = r4_val;   n_green = w4_lvl.t; n_blue = w4_lvl.p;
            end
            SEC_YG: begin
                n_red = w4_lvl.q; n_green = r4_val;   n_blue = w4_lvl.p;
            end
            SEC_GC: begin
                n_red = w4_lvl.p; n_green = r4_val;   n_blue = w4_lvl.t;
            end
            SEC_CB: begin
                n_red = w4_lvl.p; n_green = w4_lvl.q; n_blue = r4_val;
            end
            SEC_BM: begin
                n_red = w4_lvl.t; n_green = w4_lvl.p; n_blue = r4_val;
            end
            default: begin
                n_red = r4_val;   n_green = w4_lvl.p; n_blue = w4_lvl.q;
            end
        endcase
    end

    assign o_valid = r5_vld;
    assign o_red   = r5_red;
    assign o_green = r5_green;
    assign o_blue  = r5_blue;

`ifndef SYNTHESIS
    a_valid_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, 5))
        else $error("Result strobe without an accepted transaction.");

    a_grey_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ($past(i_saturation, 5) == '0)) |->
        ((o_red == $past(i_brightness, 5)) && (o_green == $past(i_brightness, 5))
         && (o_blue == $past(i_brightness, 5))))
        else $error("Zero saturation did not give grey.");

    a_value_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_red == $past(i_brightness, 5)) || (o_green == $past(i_brightness, 5))
                     || (o_blue == $past(i_brightness, 5))))
        else $error("No channel carries the brightness level.");
`endif

endmodule
